### rtl/psol_pkg.sv
package psol_pkg;

    localparam int unsigned DIV_BITS = 16;
    localparam int unsigned STG_EASE_A = DIV_BITS + 1;
    localparam int unsigned STG_EASE_B = DIV_BITS + 2;
    localparam int unsigned STG_MUL = DIV_BITS + 3;
    localparam int unsigned STG_OUT = DIV_BITS + 4;
    localparam int unsigned NUM_STG = DIV_BITS + 5;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [16:0] HALF_Q16 = 17'h08000;
    localparam logic [33:0] HALF_RND = 34'h000008000;

    localparam logic [2:0] CURVE_LINEAR = 3'd0;
    localparam logic [2:0] CURVE_IN = 3'd1;
    localparam logic [2:0] CURVE_OUT = 3'd2;
    localparam logic [2:0] CURVE_INOUT = 3'd3;
    localparam logic [2:0] CURVE_CONST = 3'd4;

    localparam logic [2:0] REG_CONTROL = 3'd0;
    localparam logic [2:0] REG_END_SIZE = 3'd1;
    localparam logic [2:0] REG_END_SIZE_X = 3'd2;
    localparam logic [2:0] REG_END_SIZE_Y = 3'd3;
    localparam logic [2:0] REG_END_SIZE_Z = 3'd4;
    localparam logic [2:0] REG_MIN_SIZE = 3'd5;
    localparam logic [2:0] REG_MAX_SIZE = 3'd6;

    localparam int unsigned CTRL_ACTIVE = 0;
    localparam int unsigned CTRL_AXES = 1;

    localparam logic [4:0] CONTROL_RST = 5'd1;
    localparam logic [15:0] MAX_SIZE_RST = 16'd25600;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] ix;
        logic [15:0] iy;
        logic [15:0] iz;
        logic [23:0] life;
        logic [23:0] rem;
        logic [15:0] quo;
        logic        sat;
    } t_div;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] ix;
        logic [15:0] iy;
        logic [15:0] iz;
        logic [16:0] ratio;
        logic [33:0] prod;
    } t_ease;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] ix;
        logic [15:0] iy;
        logic [15:0] iz;
        logic [16:0] c;
    } t_curve;

    typedef struct packed {
        logic [15:0]      tag;
        logic [2:0][32:0] p_start;
        logic [2:0][32:0] p_end;
    } t_mul;

endpackage

### rtl/particle_size_over_lifetime.sv
// Particle scale over lifetime. One item enters per cycle while the input is not
// stalled; a stall at the output lets empty stages fill before the input stalls. The
// age/lifetime divider resolves one ratio bit per stage over 16 stages, followed by the
// easing square, the blend multipliers and the clamp. The configuration port is always
// ready; write registers only while no item is in flight.
module particle_size_over_lifetime (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_particle_tag,
    input  logic [15:0] i_initial_x,
    input  logic [15:0] i_initial_y,
    input  logic [15:0] i_initial_z,
    input  logic [23:0] i_elapsed_time,
    input  logic [23:0] i_life_time,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_result_tag,
    output logic        o_updated,
    output logic [15:0] o_scale_x,
    output logic [15:0] o_scale_y,
    output logic [15:0] o_scale_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [4:0]  r_control;
    logic [15:0] r_end_size;
    logic [15:0] r_end_x;
    logic [15:0] r_end_y;
    logic [15:0] r_end_z;
    logic [15:0] r_min_size;
    logic [15:0] r_max_size;

    logic [psol_pkg::NUM_STG-1:0] r_v;
    logic [psol_pkg::NUM_STG-1:0] n_en;

    psol_pkg::t_div   r_dv [0:psol_pkg::DIV_BITS];
    psol_pkg::t_ease  r_ea;
    psol_pkg::t_curve r_cv;
    psol_pkg::t_mul   r_mu;

    psol_pkg::t_div   n_d0;
    psol_pkg::t_ease  n_ea;
    psol_pkg::t_curve n_cv;
    psol_pkg::t_mul   n_mu;

    logic [15:0] r_o_tag;
    logic        r_o_upd;
    logic [15:0] r_o_sx;
    logic [15:0] r_o_sy;
    logic [15:0] r_o_sz;

    logic [2:0]  w_curve;
    logic [16:0] w_ratio;
    logic [16:0] w_inv;
    logic [16:0] w_op;
    logic [16:0] w_cinv;
    logic [15:0] w_st [0:2];
    logic [15:0] w_en [0:2];
    logic [33:0] w_sum [0:2];
    logic [15:0] w_sz [0:2];

    assign o_cfg_ready = 1'b1;
    assign w_curve = r_control[4:2];

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= psol_pkg::CONTROL_RST;
            r_end_size <= '0;
            r_end_x <= '0;
            r_end_y <= '0;
            r_end_z <= '0;
            r_min_size <= '0;
            r_max_size <= psol_pkg::MAX_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                psol_pkg::REG_CONTROL: r_control <= i_cfg_data[4:0];
                psol_pkg::REG_END_SIZE: r_end_size <= i_cfg_data;
                psol_pkg::REG_END_SIZE_X: r_end_x <= i_cfg_data;
                psol_pkg::REG_END_SIZE_Y: r_end_y <= i_cfg_data;
                psol_pkg::REG_END_SIZE_Z: r_end_z <= i_cfg_data;
                psol_pkg::REG_MIN_SIZE: r_min_size <= i_cfg_data;
                psol_pkg::REG_MAX_SIZE: r_max_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the next one advances
    always_comb begin
        n_en[psol_pkg::NUM_STG-1] = !r_v[psol_pkg::NUM_STG-1] || !i_out_stall;
        for (int k = psol_pkg::NUM_STG - 2; k >= 0; k--) begin
            n_en[k] = !r_v[k] || n_en[k+1];
        end
    end

    assign o_in_stall = !n_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (n_en[0]) begin
                r_v[0] <= i_in_valid;
            end
            for (int k = 1; k < psol_pkg::NUM_STG; k++) begin
                if (n_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // capture item, flag saturated ratio
    always_comb begin
        n_d0.tag = i_particle_tag;
        n_d0.ix = i_initial_x;
        n_d0.iy = i_initial_y;
        n_d0.iz = i_initial_z;
        n_d0.life = i_life_time;
        n_d0.rem = i_elapsed_time;
        n_d0.quo = '0;
        n_d0.sat = (i_life_time == 24'd0) || (i_elapsed_time >= i_life_time);
    end

    always_ff @(posedge i_clk) begin
        if (n_en[0]) begin
            r_dv[0] <= n_d0;
        end
    end

    // one quotient bit per stage
    for (genvar g = 1; g <= psol_pkg::DIV_BITS; g++) begin : g_div
        logic [24:0]      w_rem2;
        logic [24:0]      w_diff;
        logic             w_ge;
        psol_pkg::t_div   w_nx;

        always_comb begin
            w_rem2 = {r_dv[g-1].rem, 1'b0};
            w_diff = w_rem2 - {1'b0, r_dv[g-1].life};
            w_ge = w_rem2 >= {1'b0, r_dv[g-1].life};
            w_nx = r_dv[g-1];
            w_nx.rem = w_ge ? w_diff[23:0] : w_rem2[23:0];
            w_nx.quo = {r_dv[g-1].quo[14:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (n_en[g]) begin
                r_dv[g] <= w_nx;
            end
        end
    end

    // easing square
    always_comb begin
        w_ratio = r_dv[psol_pkg::DIV_BITS].sat ? psol_pkg::ONE_Q16
                                                : {1'b0, r_dv[psol_pkg::DIV_BITS].quo};
        w_inv = psol_pkg::ONE_Q16 - w_ratio;
        case (w_curve)
            psol_pkg::CURVE_OUT: w_op = w_inv;
            psol_pkg::CURVE_INOUT: w_op = (w_ratio < psol_pkg::HALF_Q16) ? w_ratio : w_inv;
            default: w_op = w_ratio;
        endcase
        n_ea.tag = r_dv[psol_pkg::DIV_BITS].tag;
        n_ea.ix = r_dv[psol_pkg::DIV_BITS].ix;
        n_ea.iy = r_dv[psol_pkg::DIV_BITS].iy;
        n_ea.iz = r_dv[psol_pkg::DIV_BITS].iz;
        n_ea.ratio = w_ratio;
        n_ea.prod = {17'd0, w_op} * {17'd0, w_op};
    end

    always_ff @(posedge i_clk) begin
        if (n_en[psol_pkg::STG_EASE_A]) begin
            r_ea <= n_ea;
        end
    end

    // curve value
    always_comb begin
        n_cv.tag = r_ea.tag;
        n_cv.ix = r_ea.ix;
        n_cv.iy = r_ea.iy;
        n_cv.iz = r_ea.iz;
        case (w_curve)
            psol_pkg::CURVE_LINEAR: n_cv.c = r_ea.ratio;
            psol_pkg::CURVE_IN: n_cv.c = r_ea.prod[32:16];
            psol_pkg::CURVE_OUT: n_cv.c = psol_pkg::ONE_Q16 - r_ea.prod[32:16];
            psol_pkg::CURVE_INOUT: begin
                if (r_ea.ratio < psol_pkg::HALF_Q16) begin
                    n_cv.c = r_ea.prod[31:15];
                end else begin
                    n_cv.c = psol_pkg::ONE_Q16 - r_ea.prod[31:15];
                end
            end
            psol_pkg::CURVE_CONST: n_cv.c = '0;
            default: n_cv.c = r_ea.ratio;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_en[psol_pkg::STG_EASE_B]) begin
            r_cv <= n_cv;
        end
    end

    // blend products
    always_comb begin
        w_cinv = psol_pkg::ONE_Q16 - r_cv.c;
        if (r_control[psol_pkg::CTRL_AXES]) begin
            w_st[0] = r_cv.ix;
            w_st[1] = r_cv.iy;
            w_st[2] = r_cv.iz;
            w_en[0] = r_end_x;
            w_en[1] = r_end_y;
            w_en[2] = r_end_z;
        end else begin
            w_st[0] = r_cv.ix;
            w_st[1] = r_cv.ix;
            w_st[2] = r_cv.ix;
            w_en[0] = r_end_size;
            w_en[1] = r_end_size;
            w_en[2] = r_end_size;
        end
        n_mu.tag = r_cv.tag;
        for (int a = 0; a < 3; a++) begin
            n_mu.p_start[a] = {17'd0, w_st[a]} * {16'd0, w_cinv};
            n_mu.p_end[a] = {17'd0, w_en[a]} * {16'd0, r_cv.c};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[psol_pkg::STG_MUL]) begin
            r_mu <= n_mu;
        end
    end

    // round, clamp low then high
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            w_sum[a] = {1'b0, r_mu.p_start[a]} + {1'b0, r_mu.p_end[a]} + psol_pkg::HALF_RND;
            w_sz[a] = w_sum[a][31:16];
            if (w_sz[a] < r_min_size) begin
                w_sz[a] = r_min_size;
            end
            if (w_sz[a] > r_max_size) begin
                w_sz[a] = r_max_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[psol_pkg::STG_OUT]) begin
            r_o_tag <= r_mu.tag;
            r_o_upd <= r_control[psol_pkg::CTRL_ACTIVE];
            if (r_control[psol_pkg::CTRL_ACTIVE]) begin
                r_o_sx <= w_sz[0];
                r_o_sy <= w_sz[1];
                r_o_sz <= w_sz[2];
            end else begin
                r_o_sx <= '0;
                r_o_sy <= '0;
                r_o_sz <= '0;
            end
        end
    end

    assign o_out_valid = r_v[psol_pkg::STG_OUT];
    assign o_result_tag = r_o_tag;
    assign o_updated = r_o_upd;
    assign o_scale_x = r_o_sx;
    assign o_scale_y = r_o_sy;
    assign o_scale_z = r_o_sz;

endmodule

### tb/particle_scale_checker.sv
module particle_scale_checker
    import psol_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [15:0] i_particle_tag,
    input  logic [15:0] i_initial_x,
    input  logic [15:0] i_initial_y,
    input  logic [15:0] i_initial_z,
    input  logic [23:0] i_elapsed_time,
    input  logic [23:0] i_life_time,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [15:0] i_result_tag,
    input  logic        i_updated,
    input  logic [15:0] i_scale_x,
    input  logic [15:0] i_scale_y,
    input  logic [15:0] i_scale_z,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] tag;
        logic        updated;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sz;
    } scale_t;

    logic [4:0]  ctrl_q    = CONTROL_RST;
    logic [15:0] end_q     = '0;
    logic [15:0] end_x_q   = '0;
    logic [15:0] end_y_q   = '0;
    logic [15:0] end_z_q   = '0;
    logic [15:0] min_q     = '0;
    logic [15:0] max_q     = MAX_SIZE_RST;
    scale_t      expected_scales[$];
    int          fail_total = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic logic [16:0] life_fraction(logic [23:0] age, logic [23:0] life);
        logic [39:0] q;
        if (life == '0) begin
            return ONE_Q16;
        end
        q = {age, 16'h0000} / {16'h0000, life};
        if (q > {23'd0, ONE_Q16}) begin
            return ONE_Q16;
        end
        return q[16:0];
    endfunction

    function automatic logic [16:0] eased(logic [16:0] r, logic [2:0] curve);
        logic [16:0] inv;
        logic [35:0] sq;
        inv = ONE_Q16 - r;
        case (curve)
            CURVE_IN: begin
                sq = {19'd0, r} * {19'd0, r};
                sq = sq >> 16;
                return sq[16:0];
            end
            CURVE_OUT: begin
                sq = {19'd0, inv} * {19'd0, inv};
                sq = sq >> 16;
                return ONE_Q16 - sq[16:0];
            end
            CURVE_INOUT: begin
                if (r < HALF_Q16) begin
                    sq = 36'd2 * {19'd0, r} * {19'd0, r};
                    sq = sq >> 16;
                    return sq[16:0];
                end
                sq = 36'd2 * {19'd0, inv} * {19'd0, inv};
                sq = sq >> 16;
                return ONE_Q16 - sq[16:0];
            end
            CURVE_CONST: begin
                return '0;
            end
            default: begin
                return r;
            end
        endcase
    endfunction

    function automatic logic [15:0] blended(logic [15:0] start, logic [15:0] target,
                                            logic [16:0] c);
        logic [35:0] acc;
        logic [16:0] cinv;
        logic [15:0] v;
        cinv = ONE_Q16 - c;
        acc = {20'd0, start} * {19'd0, cinv} + {20'd0, target} * {19'd0, c}
              + {19'd0, HALF_Q16};
        v = acc[31:16];
        if (v < min_q) begin
            v = min_q;
        end
        if (v > max_q) begin
            v = max_q;
        end
        return v;
    endfunction

    function automatic scale_t predict_scale(logic [15:0] tag, logic [15:0] ix,
                                             logic [15:0] iy, logic [15:0] iz,
                                             logic [23:0] age, logic [23:0] life);
        scale_t      s;
        logic [16:0] c;
        s = '0;
        s.tag = tag;
        if (!ctrl_q[CTRL_ACTIVE]) begin
            return s;
        end
        c = eased(life_fraction(age, life), ctrl_q[4:2]);
        s.updated = 1'b1;
        if (ctrl_q[CTRL_AXES]) begin
            s.sx = blended(ix, end_x_q, c);
            s.sy = blended(iy, end_y_q, c);
            s.sz = blended(iz, end_z_q, c);
        end else begin
            s.sx = blended(ix, end_q, c);
            s.sy = s.sx;
            s.sz = s.sx;
        end
        return s;
    endfunction

    task automatic check_field(input string what, input logic [15:0] tag,
                               input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: item tag %h %s expected %h actual %h", $time, tag, what, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        scale_t want;
        if (!i_rst_n) begin
            ctrl_q  = CONTROL_RST;
            end_q   = '0;
            end_x_q = '0;
            end_y_q = '0;
            end_z_q = '0;
            min_q   = '0;
            max_q   = MAX_SIZE_RST;
            expected_scales.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_CONTROL:    ctrl_q  = i_cfg_data[4:0];
                    REG_END_SIZE:   end_q   = i_cfg_data;
                    REG_END_SIZE_X: end_x_q = i_cfg_data;
                    REG_END_SIZE_Y: end_y_q = i_cfg_data;
                    REG_END_SIZE_Z: end_z_q = i_cfg_data;
                    REG_MIN_SIZE:   min_q   = i_cfg_data;
                    REG_MAX_SIZE:   max_q   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_scales.size() == 0) begin
                    $display("%0t: unexpected item tag %h expected none actual %h %h %h %h",
                             $time, i_result_tag, i_updated, i_scale_x, i_scale_y, i_scale_z);
                    fail_total++;
                end else begin
                    want = expected_scales.pop_front();
                    check_field("result_tag", want.tag, want.tag, i_result_tag);
                    check_field("updated", want.tag, {15'd0, want.updated}, {15'd0, i_updated});
                    check_field("scale_x", want.tag, want.sx, i_scale_x);
                    check_field("scale_y", want.tag, want.sy, i_scale_y);
                    check_field("scale_z", want.tag, want.sz, i_scale_z);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_scales.push_back(predict_scale(i_particle_tag, i_initial_x,
                                                        i_initial_y, i_initial_z,
                                                        i_elapsed_time, i_life_time));
            end
        end
        o_pending    <= expected_scales.size();
        o_fail_count <= fail_total;
    end

endmodule

### tb/tb.sv
module tb;
    import psol_pkg::*;

    logic        i_clk;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [15:0] i_particle_tag = '0;
    logic [15:0] i_initial_x    = '0;
    logic [15:0] i_initial_y    = '0;
    logic [15:0] i_initial_z    = '0;
    logic [23:0] i_elapsed_time = '0;
    logic [23:0] i_life_time    = '0;
    logic        i_out_stall    = 1'b0;
    logic        i_cfg_valid    = 1'b0;
    logic [2:0]  i_cfg_index    = REG_CONTROL;
    logic [15:0] i_cfg_data     = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_result_tag;
    logic        o_updated;
    logic [15:0] o_scale_x;
    logic [15:0] o_scale_y;
    logic [15:0] o_scale_z;
    logic        o_cfg_ready;
    int          fail_count;
    int          pending;
    int          send_idle = 11;
    int          recv_idle = 69;

    particle_size_over_lifetime dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_particle_tag (i_particle_tag),
        .i_initial_x    (i_initial_x),
        .i_initial_y    (i_initial_y),
        .i_initial_z    (i_initial_z),
        .i_elapsed_time (i_elapsed_time),
        .i_life_time    (i_life_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_result_tag   (o_result_tag),
        .o_updated      (o_updated),
        .o_scale_x      (o_scale_x),
        .o_scale_y      (o_scale_y),
        .o_scale_z      (o_scale_z),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    particle_scale_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_particle_tag (i_particle_tag),
        .i_initial_x    (i_initial_x),
        .i_initial_y    (i_initial_y),
        .i_initial_z    (i_initial_z),
        .i_elapsed_time (i_elapsed_time),
        .i_life_time    (i_life_time),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_result_tag   (o_result_tag),
        .i_updated      (o_updated),
        .i_scale_x      (o_scale_x),
        .i_scale_y      (o_scale_y),
        .i_scale_z      (o_scale_z),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #1000000;
        $display("tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic send_particle(input logic [15:0] tag, input logic [15:0] ix,
                                 input logic [15:0] iy, input logic [15:0] iz,
                                 input logic [23:0] age, input logic [23:0] life);
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_particle_tag <= tag;
        i_initial_x    <= ix;
        i_initial_y    <= iy;
        i_initial_z    <= iz;
        i_elapsed_time <= age;
        i_life_time    <= life;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_setup(input logic [4:0] ctrl, input logic [15:0] end_all,
                               input logic [15:0] ex, input logic [15:0] ey,
                               input logic [15:0] ez, input logic [15:0] mn,
                               input logic [15:0] mx);
        drain_results();
        write_reg(REG_CONTROL, {11'd0, ctrl});
        write_reg(REG_END_SIZE, end_all);
        write_reg(REG_END_SIZE_X, ex);
        write_reg(REG_END_SIZE_Y, ey);
        write_reg(REG_END_SIZE_Z, ez);
        write_reg(REG_MIN_SIZE, mn);
        write_reg(REG_MAX_SIZE, mx);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(65535));
        endcase
    endfunction

    task automatic random_setup();
        logic [4:0]  ctrl;
        logic [15:0] mn;
        logic [15:0] mx;
        ctrl = 5'($urandom_range(31));
        if ($urandom_range(3) != 0) begin
            ctrl[CTRL_ACTIVE] = 1'b1;
        end
        mn = ($urandom_range(3) == 0) ? pick_size() : 16'($urandom_range(1024));
        mx = ($urandom_range(3) == 0) ? pick_size() : 16'($urandom_range(mn, 65535));
        apply_setup(ctrl, pick_size(), pick_size(), pick_size(), pick_size(), mn, mx);
    endtask

    task automatic send_random_particle();
        logic [23:0] life;
        logic [23:0] age;
        case ($urandom_range(9))
            0: life = '0;
            1: life = 24'($urandom);
            default: begin
                life = 24'($urandom) >> $urandom_range(23);
                if (life == '0) begin
                    life = 24'd1;
                end
            end
        endcase
        case ($urandom_range(9))
            0: age = 24'($urandom);
            1: age = life + 24'($urandom_range(1000));
            2: age = life;
            default: age = 24'($urandom_range(life));
        endcase
        send_particle(16'($urandom), pick_size(), pick_size(), pick_size(), age, life);
    endtask

    initial begin
        logic [2:0] curve;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000, 24'h000000, 24'h000000);
        send_particle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF);
        send_particle(16'h0001, 16'h6400, 16'h0000, 16'h0000, 24'h000000, 24'h001000);
        send_particle(16'h0002, 16'h0100, 16'h0200, 16'h0300, 24'h002000, 24'h001000);
        send_particle(16'h0003, 16'h4000, 16'h4000, 16'h4000, 24'h000800, 24'h001000);

        for (curve = CURVE_LINEAR; curve <= CURVE_CONST + 3'd1; curve++) begin
            apply_setup({curve, curve[0], 1'b1}, 16'h8000, 16'hFFFF, 16'h0000, 16'h8000,
                        16'h0000, 16'hFFFF);
            send_particle({13'd0, curve}, 16'h0000, 16'hFFFF, 16'h1234, 24'h004000, 24'h010000);
            send_particle({13'd1, curve}, 16'hFFFF, 16'h0000, 16'h4321, 24'h007FFF, 24'h010000);
            send_particle({13'd2, curve}, 16'h1000, 16'hA5A5, 16'h5A5A, 24'h008000, 24'h010000);
        end

        apply_setup({CURVE_LINEAR, 1'b0, 1'b0}, 16'h1234, 16'h1111, 16'h2222, 16'h3333,
                    16'h0000, 16'hFFFF);
        send_particle(16'hBEEF, 16'h5555, 16'h6666, 16'h7777, 24'h000400, 24'h001000);
        apply_setup({CURVE_OUT, 1'b1, 1'b1}, 16'h0000, 16'hFFFF, 16'h0000, 16'h8000,
                    16'hFFFF, 16'h0100);
        send_particle(16'hCAFE, 16'h0800, 16'h0900, 16'h0A00, 24'h000C00, 24'h001000);

        for (int phase = 0; phase < 3; phase++) begin
            send_idle = (phase == 0) ? 11 : (phase == 1) ? 69 : 0;
            recv_idle = (phase == 0) ? 69 : (phase == 1) ? 11 : 0;
            repeat (6) begin
                random_setup();
                repeat (56) send_random_particle();
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
